// ===== rtl/lse_pkg.sv =====
package lse_pkg;

  // Table and word geometry
  localparam int unsigned DataW   = 32;
  localparam int unsigned K_MAX   = 32;
  localparam int unsigned M_MAX   = 32;
  localparam int unsigned RowAw   = $clog2(M_MAX);
  localparam int unsigned CountW  = 6;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned KindW   = 2;
  localparam int unsigned RowIdxW = 5;

  // Item kinds; the fourth code carries no meaning and is dropped.
  typedef enum logic [KindW-1:0] {
    KIND_MASK_ROW = 2'd0,
    KIND_INV_ROW  = 2'd1,
    KIND_ENCODE   = 2'd2
  } kind_t;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_K_USED = 1'b0,
    CFG_M_USED = 1'b1
  } cfg_reg_t;

  // Encode sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_PARITY,
    ST_FLUSH,
    ST_OUT
  } seq_state_t;

  // Row read request from the sequencer to the two row tables
  typedef struct packed {
    logic             en;
    logic             inv_sel;
    logic [RowAw-1:0] addr;
  } rd_req_t;

  // Limit a bit count to the table size.
  function automatic logic [CountW-1:0] clamp_count(input logic [CountW-1:0] v,
                                                    input logic [CountW-1:0] limit);
    clamp_count = (v > limit) ? limit : v;
  endfunction

  // Mask with the low n bits set; n at or above the word width gives all ones.
  function automatic logic [DataW-1:0] low_mask(input logic [CountW-1:0] n);
    if (32'(n) >= DataW) begin
      low_mask = '1;
    end else begin
      low_mask = (DataW'(1) << n) - DataW'(1);
    end
  endfunction

endpackage

// ===== rtl/lse_if.sv =====
// Input channel: load items and encode items.
interface lse_in_if;
  import lse_pkg::*;
  logic               valid;
  logic               ready;
  logic [KindW-1:0]   kind;
  logic [RowIdxW-1:0] row_index;
  logic [DataW-1:0]   data_word;

  modport source (output valid, kind, row_index, data_word, input ready);
  modport sink   (input valid, kind, row_index, data_word, output ready);
endinterface

// Result channel: one codeword per encode item.
interface lse_out_if;
  import lse_pkg::*;
  logic             valid;
  logic             ready;
  logic [DataW-1:0] systematic_word;
  logic [DataW-1:0] parity_word;

  modport source (output valid, systematic_word, parity_word, input ready);
  modport sink   (input valid, systematic_word, parity_word, output ready);
endinterface

// ===== rtl/ldpc_systematic_encoder_top.sv =====
// Systematic LDPC encoder over GF(2) with a dense inverse of the parity part.
// Input channel in_ch carries three kinds of transaction: a check mask row
// load, an inverse row load (both write row row_index of their table and
// give no result) and an encode of one information word in data_word.
// Each encode gives one transaction on out_ch: the word echoed as
// systematic_word and the parity bits in parity_word.
// The cfg port sets k_used and m_used; write it only while the block idles.
// A load is written on acceptance. An encode runs one shared XOR-reduce
// unit over the table rows, one row per cycle: m check rows, then m
// inverse rows (m the effective parity count), then a flush state and an
// output state that loads the result register; with m zero the encode
// goes straight to the output state. The input stays closed until the
// encode is done; the single read port of each table sets the row pace.
// The finished codeword sits in an output register, so the next item is
// accepted while it waits; a stalled receiver holds the block only when a
// second codeword is ready to leave.
// Reset clears the control state and sets k_used and m_used to 32; the row
// tables keep no reset value and must be loaded before use.
module ldpc_systematic_encoder_top
  import lse_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  lse_in_if.sink             in_ch,
  lse_out_if.source          out_ch,
  input  logic               cfg_wr_en,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CountW-1:0]  cfg_wr_data
);

  logic [CountW-1:0] k_used_r;
  logic [CountW-1:0] m_used_r;
  logic [CountW-1:0] k_eff;
  logic [CountW-1:0] m_eff;
  logic [DataW-1:0]  k_mask;
  logic [DataW-1:0]  m_mask;
  logic              busy;
  logic              in_accept;
  logic              is_mask_ld;
  logic              is_inv_ld;
  logic              is_encode;
  logic              row_in_range;
  logic [RowAw-1:0]  wr_addr;
  rd_req_t           rd_req;
  logic [DataW-1:0]  mask_rd_data;
  logic [DataW-1:0]  inv_rd_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_used_r <= CountW'(32);
      m_used_r <= CountW'(32);
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_K_USED: k_used_r <= cfg_wr_data;
        CFG_M_USED: m_used_r <= cfg_wr_data;
        default: begin
        end
      endcase
    end
  end

  assign k_eff  = clamp_count(clamp_count(k_used_r, CountW'(K_MAX)), CountW'(DataW));
  assign m_eff  = clamp_count(clamp_count(m_used_r, CountW'(M_MAX)), CountW'(DataW));
  assign k_mask = low_mask(k_eff);
  assign m_mask = low_mask(m_eff);

  // Input decode
  assign in_ch.ready  = !busy;
  assign in_accept    = in_ch.valid && in_ch.ready;
  assign is_mask_ld   = (in_ch.kind == KIND_MASK_ROW);
  assign is_inv_ld    = (in_ch.kind == KIND_INV_ROW);
  assign is_encode    = (in_ch.kind == KIND_ENCODE);
  assign row_in_range = (32'(in_ch.row_index) < M_MAX);
  assign wr_addr      = RowAw'(in_ch.row_index);

  // Row tables
  lse_row_mem u_mask_mem (
    .clk     (clk),
    .wr_en   (in_accept && is_mask_ld && row_in_range),
    .wr_addr (wr_addr),
    .wr_data (in_ch.data_word),
    .rd_en   (rd_req.en && !rd_req.inv_sel),
    .rd_addr (rd_req.addr),
    .rd_data (mask_rd_data)
  );

  lse_row_mem u_inv_mem (
    .clk     (clk),
    .wr_en   (in_accept && is_inv_ld && row_in_range),
    .wr_addr (wr_addr),
    .wr_data (in_ch.data_word),
    .rd_en   (rd_req.en && rd_req.inv_sel),
    .rd_addr (rd_req.addr),
    .rd_data (inv_rd_data)
  );

  // Encode sequencer with the shared XOR-reduce unit
  lse_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (in_accept && is_encode),
    .word         (in_ch.data_word),
    .k_mask       (k_mask),
    .m_eff        (m_eff),
    .busy         (busy),
    .rd_req       (rd_req),
    .mask_rd_data (mask_rd_data),
    .inv_rd_data  (inv_rd_data),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .sys_word     (out_ch.systematic_word),
    .parity_word  (out_ch.parity_word)
  );

  // An accepted encode keeps the input closed on the next cycle.
  a_busy_after_encode: assert property (
    @(posedge clk) disable iff (!rst_n)
    (in_accept && is_encode) |=> !in_ch.ready
  ) else $error("input ready right after an encode was accepted");

  // Parity bits beyond the active check count stay zero.
  a_parity_high_zero: assert property (
    @(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ((out_ch.parity_word & ~m_mask) == '0)
  ) else $error("parity bit set at or above m_used");

  // Table reads happen only while an encode is in progress.
  a_read_when_busy: assert property (
    @(posedge clk) disable iff (!rst_n)
    rd_req.en |-> busy
  ) else $error("row table read while idle");

endmodule

// ===== rtl/lse_row_mem.sv =====
module lse_row_mem
  import lse_pkg::*;
(
  input  logic             clk,
  input  logic             wr_en,
  input  logic [RowAw-1:0] wr_addr,
  input  logic [DataW-1:0] wr_data,
  input  logic             rd_en,
  input  logic [RowAw-1:0] rd_addr,
  output logic [DataW-1:0] rd_data
);

  logic [DataW-1:0] mem_r [M_MAX];
  logic [DataW-1:0] rd_data_r;

  // Single write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/lse_xor_unit.sv =====
module lse_xor_unit
  import lse_pkg::*;
(
  input  logic [DataW-1:0] row,
  input  logic [DataW-1:0] vec,
  output logic             bit_out
);

  // GF(2) inner product of one table row with a bit vector.
  assign bit_out = ^(row & vec);

endmodule

// ===== rtl/lse_seq.sv =====
module lse_seq
  import lse_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DataW-1:0]  word,
  input  logic [DataW-1:0]  k_mask,
  input  logic [CountW-1:0] m_eff,
  output logic              busy,
  output rd_req_t           rd_req,
  input  logic [DataW-1:0]  mask_rd_data,
  input  logic [DataW-1:0]  inv_rd_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DataW-1:0]  sys_word,
  output logic [DataW-1:0]  parity_word
);

  seq_state_t        state_r, state_nxt;
  logic [RowAw-1:0]  cnt_r, cnt_nxt;
  logic [RowAw-1:0]  m_last_r;
  logic [CountW-1:0] m_minus1;
  logic [DataW-1:0]  word_r;
  logic [DataW-1:0]  info_r;
  logic [DataW-1:0]  checks_r;
  logic [DataW-1:0]  parity_r;
  logic              bit_vld_r;
  logic              bit_inv_r;
  logic [RowAw-1:0]  bit_idx_r;
  logic              out_valid_r;
  logic [DataW-1:0]  sys_r;
  logic [DataW-1:0]  par_r;
  logic              out_free;
  logic              load_out;
  logic              last_row;
  logic [DataW-1:0]  unit_row;
  logic [DataW-1:0]  unit_vec;
  logic              unit_bit;

  assign out_free = !out_valid_r || out_ready;
  assign last_row = (cnt_r == m_last_r);
  assign m_minus1 = m_eff - CountW'(1);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = (m_eff == '0) ? ST_OUT : ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (last_row) begin
          state_nxt = ST_PARITY;
        end
      end
      ST_PARITY: begin
        if (last_row) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State outputs: row reads, counter and result load
  always_comb begin
    rd_req   = '0;
    cnt_nxt  = cnt_r;
    load_out = 1'b0;
    busy     = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy    = 1'b0;
        cnt_nxt = '0;
      end
      ST_CHECK: begin
        rd_req.en      = 1'b1;
        rd_req.inv_sel = 1'b0;
        rd_req.addr    = cnt_r;
        cnt_nxt        = last_row ? '0 : cnt_r + RowAw'(1);
      end
      ST_PARITY: begin
        rd_req.en      = 1'b1;
        rd_req.inv_sel = 1'b1;
        rd_req.addr    = cnt_r;
        cnt_nxt        = cnt_r + RowAw'(1);
      end
      ST_FLUSH: begin
        cnt_nxt = '0;
      end
      ST_OUT: begin
        load_out = out_free;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      bit_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      bit_vld_r <= rd_req.en;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // The shared unit sees the row that returned last cycle and the vector
  // of its phase: the information word, then the check vector.
  assign unit_row = bit_inv_r ? inv_rd_data : mask_rd_data;
  assign unit_vec = bit_inv_r ? checks_r : info_r;

  lse_xor_unit u_xor (
    .row     (unit_row),
    .vec     (unit_vec),
    .bit_out (unit_bit)
  );

  // Datapath registers
  always_ff @(posedge clk) begin
    bit_inv_r <= rd_req.inv_sel;
    bit_idx_r <= rd_req.addr;
    if (start && !busy) begin
      word_r   <= word;
      info_r   <= word & k_mask;
      checks_r <= '0;
      parity_r <= '0;
      m_last_r <= m_minus1[RowAw-1:0];
    end else if (bit_vld_r) begin
      if (bit_inv_r) begin
        parity_r[bit_idx_r] <= unit_bit;
      end else begin
        checks_r[bit_idx_r] <= unit_bit;
      end
    end
    if (load_out) begin
      sys_r <= word_r;
      par_r <= parity_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign sys_word    = sys_r;
  assign parity_word = par_r;

endmodule

// ===== bench/ldpc_systematic_encoder_top_tb.sv =====
`timescale 1ns / 1ps

module ldpc_systematic_encoder_top_tb;
  import lse_pkg::*;

  // The fourth kind code has no meaning; the block must drop it silently.
  localparam logic [KindW-1:0] KIND_SPARE = 2'd3;
  // Worst encode time with all 32 rows in use, plus margin.
  localparam int unsigned SETTLE_CYCLES = 2 * M_MAX + 16;
  localparam int unsigned MAX_WAIT = 12;
  localparam int unsigned RANDOM_ITEMS = 970;

  typedef struct {
    logic [DataW-1:0] sys_word;
    logic [DataW-1:0] par_word;
  } codeword_t;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CountW-1:0] cfg_wr_data;

  lse_in_if in_ch ();
  lse_out_if out_ch ();

  ldpc_systematic_encoder_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wr_data(cfg_wr_data)
  );

  // Local copy of the encoder state.
  logic [DataW-1:0] mask_rows [M_MAX];
  logic [DataW-1:0] inv_rows [M_MAX];
  logic [CountW-1:0] info_bits_cfg;
  logic [CountW-1:0] parity_bits_cfg;

  codeword_t pending_words[$];
  int mismatch_count;
  int codewords_checked;
  int encodes_sent;
  int loads_sent;
  int spare_sent;
  int size_settings;
  bit send_burst;
  bit recv_burst;

  always #2 clk = ~clk;

  // Parity word for one information word under the current sizes.
  function automatic logic [DataW-1:0] encode_parity(input logic [DataW-1:0] word);
    int unsigned k_eff;
    int unsigned m_eff;
    logic [DataW-1:0] info;
    logic [DataW-1:0] checks;
    logic [DataW-1:0] parity;
    k_eff = 32'(info_bits_cfg);
    if (k_eff > K_MAX) k_eff = K_MAX;
    if (k_eff > DataW) k_eff = DataW;
    m_eff = 32'(parity_bits_cfg);
    if (m_eff > M_MAX) m_eff = M_MAX;
    if (m_eff > DataW) m_eff = DataW;
    info = '0;
    for (int j = 0; j < k_eff; j++) info[j] = word[j];
    checks = '0;
    for (int i = 0; i < m_eff; i++) checks[i] = ^(mask_rows[i] & info);
    parity = '0;
    for (int i = 0; i < m_eff; i++) parity[i] = ^(inv_rows[i] & checks);
    return parity;
  endfunction

  // Draw how many idle cycles a side waits; long stretches go without any.
  function automatic int unsigned draw_wait(inout bit burst);
    if ($urandom_range(0, 39) == 0) burst = !burst;
    return burst ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  // Send one input transaction and update the expected codewords on acceptance.
  task automatic send_item(input logic [KindW-1:0] kind, input logic [RowIdxW-1:0] row,
                           input logic [DataW-1:0] word);
    int unsigned gap;
    codeword_t expected;
    gap = draw_wait(send_burst);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= kind;
    in_ch.row_index <= row;
    in_ch.data_word <= word;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    case (kind)
      KIND_MASK_ROW: begin
        if (row < M_MAX) mask_rows[row] = word;
        loads_sent++;
      end
      KIND_INV_ROW: begin
        if (row < M_MAX) inv_rows[row] = word;
        loads_sent++;
      end
      KIND_ENCODE: begin
        expected.sys_word = word;
        expected.par_word = encode_parity(word);
        pending_words.push_back(expected);
        encodes_sent++;
      end
      default: begin
        spare_sent++;
      end
    endcase
  endtask

  // Stop sending and wait until the block has nothing left in flight.
  task automatic drain_block();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both size registers on consecutive cycles; the block must be idle.
  task automatic set_sizes(input logic [CountW-1:0] k_val, input logic [CountW-1:0] m_val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_K_USED;
    cfg_wr_data <= k_val;
    @(negedge clk);
    cfg_index <= CFG_M_USED;
    cfg_wr_data <= m_val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    info_bits_cfg = k_val;
    parity_bits_cfg = m_val;
    size_settings++;
  endtask

  // Fill every row of both tables so that no encode reads an unwritten row.
  task automatic load_all_rows();
    for (int r = 0; r < M_MAX; r++) begin
      send_item(KIND_MASK_ROW, RowIdxW'(r), $urandom());
      send_item(KIND_INV_ROW, RowIdxW'(r), $urandom());
    end
  endtask

  // Each item kind with extreme row indexes and data words.
  task automatic test_item_kinds();
    send_item(KIND_MASK_ROW, '0, '1);
    send_item(KIND_INV_ROW, '1, '0);
    send_item(KIND_INV_ROW, '0, 32'h0000_0001);
    send_item(KIND_MASK_ROW, '1, 32'h8000_0001);
    send_item(KIND_ENCODE, '0, '0);
    send_item(KIND_ENCODE, '1, '1);
    send_item(KIND_ENCODE, 5'd3, 32'h0000_0001);
    send_item(KIND_ENCODE, 5'd17, 32'h8000_0000);
    send_item(KIND_ENCODE, '0, 32'hAAAA_AAAA);
    // A spare kind must leave no result and no trace in the tables.
    send_item(KIND_SPARE, 5'd5, '1);
    send_item(KIND_ENCODE, '0, 32'h5555_5555);
  endtask

  // Sizes at zero, one, full and beyond the table, which the block clamps to the table size.
  task automatic test_size_extremes();
    logic [CountW-1:0] k_list [6];
    logic [CountW-1:0] m_list [6];
    k_list = '{6'd0, 6'd1, 6'd63, 6'd32, 6'd1, 6'd33};
    m_list = '{6'd0, 6'd1, 6'd63, 6'd1, 6'd32, 6'd40};
    for (int s = 0; s < 6; s++) begin
      drain_block();
      set_sizes(k_list[s], m_list[s]);
      send_item(KIND_ENCODE, '0, '1);
      send_item(KIND_ENCODE, '1, $urandom());
    end
  endtask

  // Random loads and encodes over a series of size settings.
  task automatic test_random_traffic();
    logic [CountW-1:0] k_list [9];
    logic [CountW-1:0] m_list [9];
    int unsigned per_phase;
    int unsigned pick;
    logic [DataW-1:0] word;
    k_list = '{6'd32, 6'd1, 6'd63, 6'd0, 6'd17, 6'd32, 6'd5, 6'd33, 6'd0};
    m_list = '{6'd32, 6'd1, 6'd63, 6'd5, 6'd0, 6'd9, 6'd32, 6'd48, 6'd0};
    k_list[8] = CountW'($urandom_range(0, 63));
    m_list[8] = CountW'($urandom_range(0, 63));
    per_phase = RANDOM_ITEMS / 9;
    for (int s = 0; s < 9; s++) begin
      drain_block();
      set_sizes(k_list[s], m_list[s]);
      for (int n = 0; n < per_phase; n++) begin
        pick = $urandom_range(0, 99);
        case ($urandom_range(0, 7))
          0: word = '0;
          1: word = '1;
          2: word = DataW'(1) << $urandom_range(0, DataW - 1);
          default: word = $urandom();
        endcase
        if (pick < 60) begin
          send_item(KIND_ENCODE, RowIdxW'($urandom()), word);
        end else if (pick < 78) begin
          send_item(KIND_MASK_ROW, RowIdxW'($urandom()), word);
        end else if (pick < 96) begin
          send_item(KIND_INV_ROW, RowIdxW'($urandom()), word);
        end else begin
          send_item(KIND_SPARE, RowIdxW'($urandom()), word);
        end
      end
    end
  endtask

  // Receiver: stall a random number of cycles after each transaction.
  initial begin : drive_result_ready
    int unsigned stall;
    wait (rst_n === 1'b1);
    forever begin
      stall = draw_wait(recv_burst);
      if (stall > 0) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!(out_ch.valid && out_ch.ready)) @(posedge clk);
    end
  end

  // Compare each codeword transaction with the oldest expected one.
  always @(posedge clk) begin : check_codewords
    codeword_t expected;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_words.size() == 0) begin
        $display("%0t: codeword with none expected: systematic %h parity %h", $time,
                 out_ch.systematic_word, out_ch.parity_word);
        mismatch_count++;
      end else begin
        expected = pending_words.pop_front();
        codewords_checked++;
        if (out_ch.systematic_word !== expected.sys_word) begin
          $display("%0t: systematic_word expected %h actual %h", $time, expected.sys_word,
                   out_ch.systematic_word);
          mismatch_count++;
        end
        if (out_ch.parity_word !== expected.par_word) begin
          $display("%0t: parity_word expected %h actual %h", $time, expected.par_word,
                   out_ch.parity_word);
          mismatch_count++;
        end
      end
    end
  end

  // Main sequence.
  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_K_USED;
    cfg_wr_data = '0;
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_MASK_ROW;
    in_ch.row_index = '0;
    in_ch.data_word = '0;
    out_ch.ready = 1'b0;
    info_bits_cfg = 6'd32;
    parity_bits_cfg = 6'd32;
    for (int r = 0; r < M_MAX; r++) begin
      mask_rows[r] = '0;
      inv_rows[r] = '0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    load_all_rows();
    test_item_kinds();
    test_size_extremes();
    test_random_traffic();
    drain_block();

    $display("Checked %0d codewords from %0d encodes; %0d row loads and %0d spare items sent.",
             codewords_checked, encodes_sent, loads_sent, spare_sent);
    $display("Sizes were set %0d times, including zero, one, full and out-of-range values.",
             size_settings);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Run limit, several times the slowest correct run.
  initial begin
    #2_000_000;
    $display("Timeout with %0d codewords still expected.", pending_words.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
